// ----- src/mmm_pkg.sv -----
// Shared constants and types for the Montgomery modular multiplier.
// Used by montgomery_modular_multiplier_core; depends on nothing else.
package mmm_pkg;

  // Widths of the fixed transaction fields and of the configuration port.
  localparam int unsigned FieldW    = 32;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned BitLenW   = 6;
  localparam int unsigned ExtW      = 64;

  // Default datapath width.
  localparam int unsigned DefaultWidth = 32;

  // Reset values of the configuration registers.
  localparam logic [FieldW-1:0]  ModulusReset = FieldW'(3233);
  localparam logic [BitLenW-1:0] BitLenReset  = BitLenW'(12);

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CfgModulus   = 1'b0,
    CfgBitLength = 1'b1
  } cfg_reg_e;

endpackage

// ----- src/montgomery_modular_multiplier_core.sv -----
// Pipelined radix-2 Montgomery modular multiplier, top level.
// Depends on mmm_pkg for field widths, reset values and register indexes.
//
// Usage:
//   Configuration: cfg_we_i writes cfg_wdata_i into the register chosen by
//   cfg_addr_i (modulus or bit_length). Write only while no transaction is
//   in flight; the pipeline reads the registers directly.
//   Input: a transaction is accepted at a rising edge with start_i high and
//   busy_o low. busy_o is high only in reset and the first cycle after it,
//   so a new transaction can enter on every cycle after that.
//   Output: done_o is high for exactly one cycle with product_o valid; the
//   receiver cannot stall, and results come out in the order accepted.
//   Stages: a transaction passes through one input stage, Width Montgomery
//   step stages (one operand bit each), one hand-off register, Width+1
//   restoring remainder stages (one quotient bit each, which take the final
//   reduction mod the modulus) and one output register, in that order.
//   Throughput: one transaction per cycle.
//   Reset: clears all valid bits and loads the configuration defaults
//   (modulus 3233, bit_length 12); in-flight transactions are dropped.
module montgomery_modular_multiplier_core #(
  parameter int unsigned Width = mmm_pkg::DefaultWidth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  mmm_pkg::cfg_reg_e             cfg_addr_i,
  input  logic [mmm_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [mmm_pkg::FieldW-1:0]    x_operand_i,
  input  logic [mmm_pkg::FieldW-1:0]    y_operand_i,
  output logic                          done_o,
  output logic [mmm_pkg::FieldW-1:0]    product_o
);
  import mmm_pkg::*;

  // Configuration registers.
  logic [FieldW-1:0]  mod_q;
  logic [BitLenW-1:0] len_q;
  logic               busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q  <= ModulusReset;
      len_q  <= BitLenReset;
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          CfgModulus:   mod_q <= cfg_wdata_i[FieldW-1:0];
          CfgBitLength: len_q <= cfg_wdata_i[BitLenW-1:0];
          default: ;
        endcase
      end
    end
  end

  assign busy_o = busy_q;

  // Operands and modulus brought to the datapath width.
  logic [ExtW-1:0]  x_ext, y_ext, mod_ext;
  logic [Width-1:0] x_in, y_in, m_w;
  logic             m_zero;

  assign x_ext   = ExtW'(x_operand_i);
  assign y_ext   = ExtW'(y_operand_i);
  assign mod_ext = ExtW'(mod_q);
  assign x_in    = x_ext[Width-1:0];
  assign y_in    = y_ext[Width-1:0];
  assign m_w     = mod_ext[Width-1:0];
  assign m_zero  = (m_w == '0);

  // Montgomery step pipeline: stage k holds the accumulator after k steps.
  logic             mv_q [Width+1];
  logic [Width:0]   mt_q [Width+1];
  logic [Width-1:0] mx_q [Width];
  logic [Width-1:0] my_q [Width];

  // Input stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q[0] <= 1'b0;
    end else begin
      mv_q[0] <= start_i & ~busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mx_q[0] <= x_in;
    my_q[0] <= y_in;
    mt_q[0] <= '0;
  end

  for (genvar k = 0; k < Width; k++) begin : g_mont
    localparam logic [BitLenW:0] StepIdx = (BitLenW+1)'(k);

    logic           xi, qi, act;
    logic [Width+1:0] sum;
    logic [Width:0] mt_d;

    // One accumulate-and-halve step, skipped past the programmed bit length.
    always_comb begin
      act  = ({1'b0, len_q} > StepIdx);
      xi   = mx_q[k][k];
      qi   = mt_q[k][0] ^ (xi & my_q[k][0]);
      sum  = {1'b0, mt_q[k]}
           + (xi ? {2'b00, my_q[k]} : '0)
           + (qi ? {2'b00, m_w} : '0);
      mt_d = act ? sum[Width+1:1] : mt_q[k];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        mv_q[k+1] <= 1'b0;
      end else begin
        mv_q[k+1] <= mv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      mt_q[k+1] <= mt_d;
    end

    // Operands travel only as far as later steps need them.
    if (k + 1 < Width) begin : g_opnd
      always_ff @(posedge clk_i) begin
        mx_q[k+1] <= mx_q[k];
        my_q[k+1] <= my_q[k];
      end
    end
  end

  // Restoring remainder pipeline: one dividend bit per stage, MSB first.
  logic             dv_q [Width+2];
  logic [Width:0]   dt_q [Width+2];
  logic [Width-1:0] dr_q [Width+2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else begin
      dv_q[0] <= mv_q[Width];
    end
  end

  always_ff @(posedge clk_i) begin
    dt_q[0] <= mt_q[Width];
    dr_q[0] <= '0;
  end

  for (genvar j = 0; j <= Width; j++) begin : g_div
    logic [Width:0]   trial;
    logic [Width:0]   diff;
    logic [Width-1:0] dr_d;

    // Shift in the next dividend bit and subtract the modulus if it fits.
    always_comb begin
      trial = {dr_q[j], dt_q[j][Width-j]};
      diff  = trial - {1'b0, m_w};
      dr_d  = (trial >= {1'b0, m_w}) ? diff[Width-1:0] : trial[Width-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j+1] <= 1'b0;
      end else begin
        dv_q[j+1] <= dv_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      dt_q[j+1] <= dt_q[j];
      dr_q[j+1] <= dr_d;
    end
  end

  // Output register. A zero modulus skips the reduction; the accumulator
  // is then below Y and fits the datapath width.
  logic             done_q;
  logic [Width-1:0] prod_q;
  logic [ExtW-1:0]  prod_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_q[Width+1];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= m_zero ? dt_q[Width+1][Width-1:0] : dr_q[Width+1];
  end

  assign prod_ext  = ExtW'(prod_q);
  assign done_o    = done_q;
  assign product_o = prod_ext[FieldW-1:0];

endmodule

// ----- tb/sv/tb_montgomery_modular_multiplier_core.sv -----
// Self-checking testbench for montgomery_modular_multiplier_core.
// Depends on mmm_pkg and the core; a queue-fed driver and a clocked monitor
// check every product against a bit-serial Montgomery predictor.
`timescale 1ns / 1ps

module tb_montgomery_modular_multiplier_core;
  import mmm_pkg::*;

  localparam int PipeLatency = 2 * DefaultWidth + 4;
  localparam int StallLimit  = 2000;
  localparam int RandomPhases = 12;
  localparam int ItemsPerPhase = 157;

  typedef enum logic {
    JobMultiply,
    JobWriteReg
  } job_kind_e;

  typedef struct {
    job_kind_e          kind;
    cfg_reg_e           addr;
    logic [FieldW-1:0]  data;
    logic [FieldW-1:0]  x;
    logic [FieldW-1:0]  y;
  } mul_job_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  cfg_reg_e             cfg_addr_i = CfgModulus;
  logic [CfgDataW-1:0]  cfg_wdata_i = '0;
  logic                 start_i = 1'b0;
  logic                 busy_o;
  logic [FieldW-1:0]    x_operand_i = '0;
  logic [FieldW-1:0]    y_operand_i = '0;
  logic                 done_o;
  logic [FieldW-1:0]    product_o;

  mul_job_t             job_queue[$];
  logic [FieldW-1:0]    product_queue[$];
  logic [FieldW-1:0]    mirror_modulus = ModulusReset;
  logic [BitLenW-1:0]   mirror_bit_length = BitLenReset;
  logic                 taken = 1'b0;
  int                   sent_count = 0;
  int                   fail_count = 0;
  int                   stall_cycles = 0;

  montgomery_modular_multiplier_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .x_operand_i (x_operand_i),
    .y_operand_i (y_operand_i),
    .done_o      (done_o),
    .product_o   (product_o)
  );

  // Free-running clock with a 4 ns period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Bit-serial radix-2 Montgomery product followed by the final reduction.
  function automatic logic [FieldW-1:0] montgomery_product(
    input logic [FieldW-1:0]  x,
    input logic [FieldW-1:0]  y,
    input logic [FieldW-1:0]  modulus,
    input logic [BitLenW-1:0] bit_length
  );
    logic [33:0] acc;
    logic [34:0] sum;
    logic        q;
    int          steps;
    int          i;
    steps = (bit_length > DefaultWidth) ? DefaultWidth : int'(bit_length);
    acc = '0;
    for (i = 0; i < steps; i++) begin
      q = acc[0] ^ (x[i] & y[0]);
      sum = acc;
      if (x[i]) sum = sum + y;
      if (q) sum = sum + modulus;
      acc = sum[34:1];
    end
    if (modulus != '0 && acc >= modulus) acc = acc % modulus;
    return acc[FieldW-1:0];
  endfunction

  // Operand picker: values below the modulus in four picks of ten, else extremes, powers of two and noise.
  function automatic logic [FieldW-1:0] random_operand(input logic [FieldW-1:0] modulus);
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return 32'd1 << $urandom_range(31);
      3, 4, 5, 6: return (modulus != '0) ? ($urandom % modulus) : $urandom;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_write(input cfg_reg_e addr, input logic [FieldW-1:0] data);
    mul_job_t job;
    job = '{kind: JobWriteReg, addr: addr, data: data, x: '0, y: '0};
    job_queue.push_back(job);
  endtask

  task automatic queue_operands(input logic [FieldW-1:0] x, input logic [FieldW-1:0] y);
    mul_job_t job;
    job = '{kind: JobMultiply, addr: CfgModulus, data: '0, x: x, y: y};
    job_queue.push_back(job);
  endtask

  // Driver: applies one queued job per free slot at the falling edge. A
  // register write waits until every outstanding product has come back.
  always @(negedge clk_i) begin : drive
    logic     holding;
    logic     nxt_start;
    logic     nxt_we;
    int       idle_pct;
    mul_job_t job;
    if (rst_ni) begin
      holding = start_i && !taken;
      nxt_start = holding;
      nxt_we = 1'b0;
      idle_pct = (sent_count < 633) ? 20 : (sent_count < 1266) ? 85 : 0;
      if (!holding && job_queue.size() > 0) begin
        if (job_queue[0].kind == JobWriteReg) begin
          if (product_queue.size() == 0) begin
            job = job_queue.pop_front();
            nxt_we = 1'b1;
            cfg_addr_i <= job.addr;
            cfg_wdata_i <= job.data;
          end
        end else if ($urandom_range(99) >= idle_pct) begin
          job = job_queue.pop_front();
          nxt_start = 1'b1;
          x_operand_i <= job.x;
          y_operand_i <= job.y;
          sent_count++;
        end
      end
      // Operand ports carry noise whenever no transaction is offered.
      if (!nxt_start) begin
        x_operand_i <= $urandom;
        y_operand_i <= $urandom;
      end
      start_i <= nxt_start;
      cfg_we_i <= nxt_we;
    end
  end

  // Monitor: mirrors register writes, predicts each accepted transaction and
  // checks every product in order. Also runs the stall watchdog.
  always @(posedge clk_i) begin : monitor
    logic [FieldW-1:0] want;
    if (!rst_ni) begin
      taken = 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CfgModulus:   mirror_modulus = cfg_wdata_i[FieldW-1:0];
          CfgBitLength: mirror_bit_length = cfg_wdata_i[BitLenW-1:0];
          default: ;
        endcase
      end
      taken = start_i && !busy_o;
      if (taken) begin
        product_queue.push_back(montgomery_product(x_operand_i, y_operand_i,
                                                   mirror_modulus, mirror_bit_length));
      end
      if (done_o) begin
        if (product_queue.size() == 0) begin
          $error("product: unexpected result %h", product_o);
          fail_count++;
        end else begin
          want = product_queue.pop_front();
          if (product_o !== want) begin
            $error("product: expected %h, actual %h", want, product_o);
            fail_count++;
          end
        end
      end
      if (taken || done_o || cfg_we_i) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= StallLimit) begin
          $display("Some tests failed");
          $finish;
        end
      end
    end
  end

  // Stimulus plan and end of run.
  initial begin : stimulus
    logic [FieldW-1:0]  modulus;
    logic [BitLenW-1:0] bit_length;
    logic [FieldW-1:0]  phase_mod[RandomPhases];
    logic [BitLenW-1:0] phase_len[RandomPhases];
    int p;
    int n;

    // Directed products under the reset configuration (modulus 3233, 12 bits).
    queue_operands(32'h0000_0000, 32'h0000_0000);
    queue_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_operands(32'h0000_0FFF, 32'h0000_0CA0);
    queue_operands(32'hFFFF_F000, 32'h0000_04D2);
    queue_operands(32'h0000_0001, 32'h0000_0001);
    queue_operands(32'h0000_0CA0, 32'h0000_0CA0);
    queue_operands(32'h0000_0800, 32'hFFFF_FFFE);
    queue_operands(32'h0000_0ABC, 32'h5A5A_5A5B);

    // Zero bit length: no steps, so the product is zero.
    queue_write(CfgBitLength, {26'h3FF_FFFF, 6'd0});
    queue_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_operands(32'h1234_5678, 32'h0000_0C00);
    // Bit length above the datapath width is clamped to the width.
    queue_write(CfgBitLength, 32'd45);
    queue_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_operands(32'h8000_0001, 32'h0000_0C9F);
    // Zero modulus: no reduction term and no final subtraction.
    queue_write(CfgModulus, 32'h0000_0000);
    queue_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_operands(32'hDEAD_BEEF, 32'h0000_0001);
    // Even modulus: halving drops the low bit, final step is a plain remainder.
    queue_write(CfgModulus, 32'hFFFF_FFFE);
    queue_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_operands(32'h0F0F_0F0F, 32'hFFFF_FFFD);
    queue_write(CfgModulus, 32'h0000_0010);
    queue_operands(32'h7777_7777, 32'h0000_000F);

    // Register settings for the random part, extremes first.
    phase_mod[0]  = 32'hFFFF_FFFF;            phase_len[0]  = 6'd32;
    phase_mod[1]  = 32'h0000_0001;            phase_len[1]  = 6'd1;
    phase_mod[2]  = 32'h0000_0003;            phase_len[2]  = 6'd2;
    phase_mod[3]  = $urandom | 32'h8000_0001; phase_len[3]  = 6'd32;
    phase_mod[4]  = 32'h0000_0000;            phase_len[4]  = 6'd20;
    phase_mod[5]  = $urandom & 32'hFFFF_FFFE; phase_len[5]  = 6'd16;
    phase_mod[6]  = $urandom | 32'h1;         phase_len[6]  = 6'd0;
    phase_mod[7]  = $urandom | 32'h1;         phase_len[7]  = 6'd63;
    phase_mod[8]  = 32'h8000_0001;            phase_len[8]  = 6'd31;
    phase_mod[9]  = $urandom_range(65535) | 32'h1;
    phase_len[9]  = 6'($urandom_range(1, 32));
    phase_mod[10] = $urandom;                 phase_len[10] = 6'($urandom_range(63));
    phase_mod[11] = ModulusReset;             phase_len[11] = BitLenReset;

    for (p = 0; p < RandomPhases; p++) begin
      modulus = phase_mod[p];
      bit_length = phase_len[p];
      queue_write(CfgModulus, modulus);
      queue_write(CfgBitLength, {6'($urandom), 20'($urandom), bit_length});
      for (n = 0; n < ItemsPerPhase; n++) begin
        queue_operands(random_operand(modulus), random_operand(modulus));
      end
    end

    // Single reset pulse at the start of the run.
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Wait for the driver to drain its queue and the pipeline to empty.
    do begin
      @(negedge clk_i);
    end while (job_queue.size() != 0 || start_i || product_queue.size() != 0);
    repeat (2 * PipeLatency) @(negedge clk_i);

    if (fail_count == 0 && product_queue.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
